// ===== hw/rtl/psrc_pkg.sv =====
`default_nettype none

package psrc_pkg;

  // command codes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_COUNT  = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;
  localparam logic [2:0] OP_LENGTH = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_BAD  = 2'd3;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VALUE_W = 7;
  localparam int unsigned RAD_W   = 24;
  localparam int unsigned LIM_W   = 2 * RAD_W;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,      // take word from the cell above (cell 0 takes the new point)
    CELL_ROT,       // take word from the cell below, last cell wraps to cell 0
    CELL_ROT_PEND   // as CELL_ROT, but only cells at or behind the token
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       pend_load;
    logic       pend_step;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LIMIT,
    ST_ROTATE,
    ST_DRAIN,
    ST_CFIN,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psrc_cell.sv =====
`default_nettype none

module psrc_cell (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  psrc_pkg::cell_ctrl_t        ctrl,
  input  wire  [psrc_pkg::WORD_W-1:0]       key,
  input  wire  [psrc_pkg::WORD_W-1:0]       prev_word,
  input  wire  [psrc_pkg::WORD_W-1:0]       next_word,
  input  wire                               prev_pend,
  output logic [psrc_pkg::WORD_W-1:0]       word,
  output logic                              pend,
  output logic                              hit
);

  logic [psrc_pkg::WORD_W-1:0] word_r;
  logic                        pend_r;

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      psrc_pkg::CELL_PUSH:     word_r <= prev_word;
      psrc_pkg::CELL_ROT:      word_r <= next_word;
      psrc_pkg::CELL_ROT_PEND: begin
        if (pend_r) begin
          word_r <= next_word;
        end
      end
      default:                 word_r <= word_r;
    endcase
  end

  // thermometer of cells the search token has not yet passed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (ctrl.pend_load) begin
      pend_r <= 1'b1;
    end else if (ctrl.pend_step) begin
      pend_r <= prev_pend;
    end
  end

  assign word = word_r;
  assign pend = pend_r;
  // token sits here when this cell is pending and the one above is not
  assign hit  = pend_r & ~prev_pend & (word_r == key);

endmodule

`default_nettype wire

// ===== hw/rtl/psrc_dist.sv =====
`default_nettype none

module psrc_dist #(
  parameter int unsigned CNT_W = 7
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          clr,
  input  wire                          feed_v,
  input  wire  [psrc_pkg::WORD_W-1:0]  word,
  input  wire  [31:0]                  lim_hi,
  output logic [CNT_W-1:0]             acc
);

  logic [15:0] x_abs, y_abs;
  logic [31:0] xsq_r, ysq_r;
  logic        s1_v_r;
  logic [32:0] d2;
  logic        in_circle;
  logic [CNT_W-1:0] acc_r, acc_nxt;

  // magnitude of a 16-bit two's complement half; -32768 maps to 0x8000
  assign x_abs = word[31] ? (~word[31:16] + 16'd1) : word[31:16];
  assign y_abs = word[15] ? (~word[15:0] + 16'd1) : word[15:0];

  always_ff @(posedge clk) begin
    xsq_r <= {16'd0, x_abs} * {16'd0, x_abs};
    ysq_r <= {16'd0, y_abs} * {16'd0, y_abs};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= feed_v;
    end
  end

  // (d2 << 16) <= r*r  is the same as  d2 <= (r*r) >> 16
  assign d2        = {1'b0, xsq_r} + {1'b0, ysq_r};
  assign in_circle = d2 <= {1'b0, lim_hi};

  always_comb begin
    acc_nxt = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end else if (s1_v_r && in_circle) begin
      acc_nxt = acc_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== hw/rtl/point_stack_with_radius_count.sv =====
`default_nettype none

// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | in_tdata: op, x_coord, y_coord, radius
// out_    | out | out_tvalid/out_tready | out_tdata: status, value, found
//
// Push, pop, length and bad command go straight from idle to the response
// state; search and delete walk the entries from the top; count turns the
// cell ring once past the distance unit and then drains it. Reset (rst_n
// low, synchronous) empties the stack.
// One command is in flight at a time; a finished result sits in the output
// register, so the next beat is taken while out_tready is low.

module point_stack_with_radius_count #(
  parameter int unsigned DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // op[2:0], x_coord[18:3], y_coord[34:19], radius[58:35]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // status[1:0], value[8:2], found[9]
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned W     = psrc_pkg::WORD_W;

  // ---------------------------------------------------------------
  // input unpacking
  // ---------------------------------------------------------------
  logic                        in_fire;
  logic [2:0]                  in_op;
  logic [W-1:0]                in_key;
  logic [psrc_pkg::RAD_W-1:0]  in_radius;

  assign in_fire   = in_tvalid & in_tready;
  assign in_op     = in_tdata[2:0];
  assign in_key    = {in_tdata[18:3], in_tdata[34:19]};  // x upper, y lower
  assign in_radius = in_tdata[58:35];

  // ---------------------------------------------------------------
  // state
  // ---------------------------------------------------------------
  psrc_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]            count_r, count_nxt;   // stored points
  logic [CNT_W-1:0]            step_r, step_nxt;     // walk / rotate position
  logic [2:0]                  op_r;
  logic [W-1:0]                key_r;
  logic [psrc_pkg::RAD_W-1:0]  radius_r;
  logic [psrc_pkg::LIM_W-1:0]  lim_r;

  logic [1:0]                  res_status_r, res_status_nxt;
  logic [psrc_pkg::VALUE_W-1:0] res_value_r, res_value_nxt;
  logic                        res_found_r, res_found_nxt;

  logic                        out_valid_r;
  logic [15:0]                 out_data_r;
  logic                        out_free, out_load;

  psrc_pkg::cell_ctrl_t        cell_ctrl;
  logic                        acc_clr, feed_v;

  // ---------------------------------------------------------------
  // cell chain: cell 0 holds the newest point
  // ---------------------------------------------------------------
  logic [W-1:0]     word_w [DEPTH];
  logic [DEPTH-1:0] pend_w;
  logic [DEPTH-1:0] hit_w;
  logic             hit_any;
  logic             in_range;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % DEPTH;
    logic [W-1:0] prev_word;
    logic         prev_pend;

    if (i == 0) begin : g_head
      assign prev_word = in_key;
      assign prev_pend = 1'b0;
    end else begin : g_body
      assign prev_word = word_w[i-1];
      assign prev_pend = pend_w[i-1];
    end

    psrc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .key       (key_r),
      .prev_word (prev_word),
      .next_word (word_w[NXT]),
      .prev_pend (prev_pend),
      .word      (word_w[i]),
      .pend      (pend_w[i]),
      .hit       (hit_w[i])
    );
  end

  assign hit_any  = |hit_w;
  assign in_range = step_r < count_r;

  // ---------------------------------------------------------------
  // distance unit at the head of the ring
  // ---------------------------------------------------------------
  logic [CNT_W-1:0] acc;

  psrc_dist #(
    .CNT_W (CNT_W)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (acc_clr),
    .feed_v (feed_v),
    .word   (word_w[0]),
    .lim_hi (lim_r[psrc_pkg::LIM_W-1:16]),
    .acc    (acc)
  );

  // ---------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------
  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = (state_r == psrc_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psrc_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            psrc_pkg::OP_DELETE,
            psrc_pkg::OP_SEARCH: state_nxt = psrc_pkg::ST_WALK;
            psrc_pkg::OP_COUNT:  state_nxt = psrc_pkg::ST_LIMIT;
            default:             state_nxt = psrc_pkg::ST_RESP;
          endcase
        end
      end
      psrc_pkg::ST_WALK: begin
        if (!in_range || hit_any) begin
          state_nxt = psrc_pkg::ST_RESP;
        end
      end
      psrc_pkg::ST_LIMIT:  state_nxt = psrc_pkg::ST_ROTATE;
      psrc_pkg::ST_ROTATE: begin
        if (step_r == CNT_W'(DEPTH - 1)) begin
          state_nxt = psrc_pkg::ST_DRAIN;
        end
      end
      psrc_pkg::ST_DRAIN:  state_nxt = psrc_pkg::ST_CFIN;
      psrc_pkg::ST_CFIN:   state_nxt = psrc_pkg::ST_RESP;
      psrc_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = psrc_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = psrc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // control outputs
  // ---------------------------------------------------------------
  always_comb begin
    cell_ctrl      = '{mode: psrc_pkg::CELL_HOLD, pend_load: 1'b0, pend_step: 1'b0};
    count_nxt      = count_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_found_nxt  = res_found_r;
    acc_clr        = 1'b0;
    feed_v         = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      psrc_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_status_nxt = psrc_pkg::STAT_OK;
          res_value_nxt  = '0;
          res_found_nxt  = 1'b0;
          case (in_op)
            psrc_pkg::OP_PUSH: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = psrc_pkg::STAT_FULL;
              end else begin
                cell_ctrl.mode = psrc_pkg::CELL_PUSH;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            psrc_pkg::OP_POP: begin
              if (count_r == '0) begin
                res_status_nxt = psrc_pkg::STAT_MISS;
              end else begin
                cell_ctrl.mode = psrc_pkg::CELL_ROT;
                count_nxt      = count_r - CNT_W'(1);
              end
            end
            psrc_pkg::OP_DELETE,
            psrc_pkg::OP_SEARCH: begin
              cell_ctrl.pend_load = 1'b1;
              step_nxt            = '0;
            end
            psrc_pkg::OP_COUNT: begin
              step_nxt = '0;
            end
            psrc_pkg::OP_LENGTH: begin
              res_value_nxt = psrc_pkg::VALUE_W'(count_r);
            end
            default: begin
              res_status_nxt = psrc_pkg::STAT_BAD;
            end
          endcase
        end
      end
      psrc_pkg::ST_WALK: begin
        if (!in_range) begin
          // ran off the occupied part without a match
          res_status_nxt = (op_r == psrc_pkg::OP_DELETE) ? psrc_pkg::STAT_MISS
                                                         : psrc_pkg::STAT_OK;
        end else if (hit_any) begin
          if (op_r == psrc_pkg::OP_DELETE) begin
            // close the gap: every cell from the match down moves up one
            cell_ctrl.mode = psrc_pkg::CELL_ROT_PEND;
            count_nxt      = count_r - CNT_W'(1);
          end else begin
            res_found_nxt = 1'b1;
          end
        end else begin
          cell_ctrl.pend_step = 1'b1;
          step_nxt            = step_r + CNT_W'(1);
        end
      end
      psrc_pkg::ST_LIMIT: begin
        acc_clr  = 1'b1;
        step_nxt = '0;
      end
      psrc_pkg::ST_ROTATE: begin
        // a full turn brings every word back to its own cell
        cell_ctrl.mode = psrc_pkg::CELL_ROT;
        feed_v         = in_range;
        step_nxt       = step_r + CNT_W'(1);
      end
      psrc_pkg::ST_CFIN: begin
        res_status_nxt = (acc == '0) ? psrc_pkg::STAT_MISS : psrc_pkg::STAT_OK;
        res_value_nxt  = psrc_pkg::VALUE_W'(acc);
      end
      psrc_pkg::ST_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psrc_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_found_r  <= res_found_nxt;
    if (in_fire) begin
      op_r     <= in_op;
      key_r    <= in_key;
      radius_r <= in_radius;
    end
    if (state_r == psrc_pkg::ST_LIMIT) begin
      // Q32.16
      lim_r <= {{psrc_pkg::RAD_W{1'b0}}, radius_r} * {{psrc_pkg::RAD_W{1'b0}}, radius_r};
    end
    if (out_load) begin
      out_data_r <= {6'd0, res_found_r, res_value_r, res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
